>>> design/llars_pkg.sv
`timescale 1ns / 1ps

package llars_pkg;

   localparam int RowBits            = 48;
   localparam int CountBits          = 6;
   localparam int MaskBits           = 9;
   localparam int NeighborBits       = 4;
   localparam int GroupBits          = 8;
   localparam int GroupCount         = RowBits / GroupBits;
   localparam int GroupSumBits       = 4;
   localparam int GridColumnsDefault = 48;

   localparam logic [MaskBits-1:0] BirthMaskReset   = 9'd8;
   localparam logic [MaskBits-1:0] SurviveMaskReset = 9'd12;

   localparam int CsrAddrBits = 3;

   typedef enum logic {
      CSR_BIRTH_MASK   = 1'b0,
      CSR_SURVIVE_MASK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [RowBits-1:0] row_bits;
      logic               last_row;
   } req_type;

   typedef struct packed {
      logic [RowBits-1:0]   next_row_bits;
      logic [CountBits-1:0] row_alive_count;
      logic [CountBits-1:0] row_changed_count;
      logic                 last_of_frame;
   } rsp_type;

   // per-column buffer control, broadcast along the row
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

>>> design/llars_cell.sv
`timescale 1ns / 1ps

module llars_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  llars_pkg::cell_ctrl_type        ctrl,
   input  logic [llars_pkg::MaskBits-1:0]  birth_mask,
   input  logic [llars_pkg::MaskBits-1:0]  survive_mask,
   input  logic                            row_bit,
   input  logic                            below_bit,
   input  logic                            left_above,
   input  logic                            left_mid,
   input  logic                            left_below,
   input  logic                            right_above,
   input  logic                            right_mid,
   input  logic                            right_below,
   output logic                            above_out,
   output logic                            mid_out,
   output logic                            next_bit
);
   import llars_pkg::*;

   logic                    above_ff, above_in;
   logic                    mid_ff, mid_in;
   logic [7:0]              neighbors;
   logic [NeighborBits-1:0] count;
   logic [MaskBits-1:0]     rule;

   always_comb begin
      above_in = above_ff;
      mid_in   = mid_ff;
      if (ctrl.clear) begin
         above_in = 1'b0;
         mid_in   = 1'b0;
      end else if (ctrl.shift) begin
         above_in = mid_ff;
         mid_in   = row_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= 1'b0;
         mid_ff   <= 1'b0;
      end else begin
         above_ff <= above_in;
         mid_ff   <= mid_in;
      end
   end

   always_comb begin
      neighbors = {left_above, above_ff, right_above, left_mid,
                   right_mid, left_below, below_bit, right_below};
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + {{(NeighborBits-1){1'b0}}, neighbors[i]};
      end
      rule     = mid_ff ? survive_mask : birth_mask;
      next_bit = rule[count];
   end

   assign above_out = above_ff;
   assign mid_out   = mid_ff;

endmodule

>>> design/life_like_automaton_row_step_unit.sv
`timescale 1ns / 1ps

// Life-like (B/S rule) row stepper. Rows of one generation enter top to bottom,
// one per cycle while req_ready is high; each row's next generation leaves one
// row late, with its live count and changed-cell count. A row of cells, one per
// grid column, holds the two buffered rows and evaluates every column in
// parallel, so the rate is one row per cycle unless stalled. After the row
// marked last, the cells emit the bottom row against a dead row below and then
// clear for the next frame; req_ready is low until they clear. The cell row's
// result is registered, summed into group counts and held in the output
// register. Cells outside the grid are dead; bits at or above min(GRID_COLUMNS,
// 48) are ignored on input and zero on output. Birth/survive masks sit at byte
// addresses 0 and 4 and should only be written while the block is empty.
module life_like_automaton_row_step_unit #(
   parameter int GRID_COLUMNS = llars_pkg::GridColumnsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  llars_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output llars_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [llars_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import llars_pkg::*;

   localparam int GridWidth = (GRID_COLUMNS < RowBits) ? GRID_COLUMNS : RowBits;

   // configuration
   logic [MaskBits-1:0] birth_ff, birth_in;
   logic [MaskBits-1:0] survive_ff, survive_in;
   logic                csr_write;
   csr_index_type       csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      birth_in   = birth_ff;
      survive_in = survive_ff;
      csr_prdata = '0;
      unique case (csr_index)
         CSR_BIRTH_MASK: begin
            csr_prdata[MaskBits-1:0] = birth_ff;
            if (csr_write) birth_in = csr_pwdata[MaskBits-1:0];
         end
         CSR_SURVIVE_MASK: begin
            csr_prdata[MaskBits-1:0] = survive_ff;
            if (csr_write) survive_in = csr_pwdata[MaskBits-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff   <= BirthMaskReset;
         survive_ff <= SurviveMaskReset;
      end else begin
         birth_ff   <= birth_in;
         survive_ff <= survive_in;
      end
   end

   // pipeline handshake
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready;
   logic flush_ff, flush_in;
   logic middle_valid_ff, middle_valid_in;
   logic accept;
   cell_ctrl_type cell_ctrl;

   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready && !flush_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cell_ctrl.shift = accept;
      cell_ctrl.clear = flush_ff && s1_ready;
      s1_valid_in     = (accept && middle_valid_ff) || flush_ff;
      flush_in        = flush_ff;
      middle_valid_in = middle_valid_ff;
      if (cell_ctrl.clear) begin
         flush_in        = 1'b0;
         middle_valid_in = 1'b0;
      end else if (accept) begin
         flush_in        = req_payload.last_row;
         middle_valid_in = !req_payload.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff        <= 1'b0;
         middle_valid_ff <= 1'b0;
      end else begin
         flush_ff        <= flush_in;
         middle_valid_ff <= middle_valid_in;
      end
   end

   // row of cells
   logic [GridWidth-1:0] row_w, below_w, above_w, mid_w, next_w;
   logic [GridWidth+1:0] above_pad, mid_pad, below_pad;

   assign row_w     = req_payload.row_bits[GridWidth-1:0];
   assign below_w   = flush_ff ? '0 : row_w;
   assign above_pad = {1'b0, above_w, 1'b0};
   assign mid_pad   = {1'b0, mid_w, 1'b0};
   assign below_pad = {1'b0, below_w, 1'b0};

   for (genvar c = 0; c < GridWidth; c++) begin : g_col
      llars_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .birth_mask   (birth_ff),
         .survive_mask (survive_ff),
         .row_bit      (row_w[c]),
         .below_bit    (below_w[c]),
         .left_above   (above_pad[c]),
         .left_mid     (mid_pad[c]),
         .left_below   (below_pad[c]),
         .right_above  (above_pad[c+2]),
         .right_mid    (mid_pad[c+2]),
         .right_below  (below_pad[c+2]),
         .above_out    (above_w[c]),
         .mid_out      (mid_w[c]),
         .next_bit     (next_w[c])
      );
   end

   // stage 1: next row and changed bits
   logic [RowBits-1:0] next_full, diff_full;
   logic [RowBits-1:0] s1_next_ff, s1_diff_ff;
   logic               s1_last_ff;

   always_comb begin
      next_full = '0;
      diff_full = '0;
      next_full[GridWidth-1:0] = next_w;
      diff_full[GridWidth-1:0] = next_w ^ mid_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_ready) begin
         s1_next_ff <= next_full;
         s1_diff_ff <= diff_full;
         s1_last_ff <= flush_ff;
      end
   end

   // stage 2: per-byte counts
   logic [GroupSumBits-1:0] alive_grp_in [GroupCount];
   logic [GroupSumBits-1:0] chg_grp_in   [GroupCount];
   logic [GroupSumBits-1:0] s2_alive_grp_ff [GroupCount];
   logic [GroupSumBits-1:0] s2_chg_grp_ff   [GroupCount];
   logic [RowBits-1:0]      s2_next_ff;
   logic                    s2_last_ff;

   always_comb begin
      for (int g = 0; g < GroupCount; g++) begin
         alive_grp_in[g] = '0;
         chg_grp_in[g]   = '0;
         for (int b = 0; b < GroupBits; b++) begin
            alive_grp_in[g] = alive_grp_in[g]
                              + {{(GroupSumBits-1){1'b0}}, s1_next_ff[g*GroupBits+b]};
            chg_grp_in[g]   = chg_grp_in[g]
                              + {{(GroupSumBits-1){1'b0}}, s1_diff_ff[g*GroupBits+b]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         s2_alive_grp_ff <= alive_grp_in;
         s2_chg_grp_ff   <= chg_grp_in;
         s2_next_ff      <= s1_next_ff;
         s2_last_ff      <= s1_last_ff;
      end
   end

   // stage 3: output register
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.next_row_bits     = s2_next_ff;
      rsp_in.last_of_frame     = s2_last_ff;
      rsp_in.row_alive_count   = '0;
      rsp_in.row_changed_count = '0;
      for (int g = 0; g < GroupCount; g++) begin
         rsp_in.row_alive_count   = rsp_in.row_alive_count
            + {{(CountBits-GroupSumBits){1'b0}}, s2_alive_grp_ff[g]};
         rsp_in.row_changed_count = rsp_in.row_changed_count
            + {{(CountBits-GroupSumBits){1'b0}}, s2_chg_grp_ff[g]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s3_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> test/life_like_automaton_row_step_unit_test.sv
`timescale 1ns / 1ps

module life_like_automaton_row_step_unit_test;
   import llars_pkg::*;

   localparam int GridColumns  = GridColumnsDefault;
   localparam int GridWidth    = (GridColumns < RowBits) ? GridColumns : RowBits;
   localparam logic [RowBits-1:0] GridMask =
      (GridWidth >= RowBits) ? {RowBits{1'b1}} : ((48'd1 << GridWidth) - 48'd1);
   localparam int RandomRows   = 1530;
   localparam int SettleCycles = 10;
   localparam int HoldCycles   = 300;
   localparam int CycleLimit   = 500000;

   typedef enum logic {
      PLAN_ROW,
      PLAN_MASKS
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type         kind;
      logic [MaskBits-1:0]   birth;
      logic [MaskBits-1:0]   survive;
      req_type               row_in;
      logic                  check_golden;
      rsp_type               golden;
   } plan_entry_type;

   localparam rsp_type NoGolden = '0;
   localparam int NumDirected = 24;

   // Typed results are all single-row frames, so each row gives exactly one item.
   localparam plan_entry_type DirectedPlan [NumDirected] = '{
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h0, 1'b1}, 1'b1, '{48'h0, 6'd0, 6'd0, 1'b1}},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hFFFF_FFFF_FFFF, 1'b1}, 1'b1,
        '{48'h7FFF_FFFF_FFFE, 6'd46, 6'd2, 1'b1}},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h1, 1'b1}, 1'b1, '{48'h0, 6'd0, 6'd1, 1'b1}},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h8000_0000_0000, 1'b1}, 1'b1,
        '{48'h0, 6'd0, 6'd1, 1'b1}},
      // blinker
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h0, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h1C00, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h0, 1'b1}, 1'b0, NoGolden},
      // two-row frame
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hFFFF_FFFF_FFFF, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hFFFF_FFFF_FFFF, 1'b1}, 1'b0, NoGolden},
      // glider against the low edge
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h2, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h4, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h7, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h0, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h0, 1'b1}, 1'b0, NoGolden},
      // both edge columns
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hC000_0000_0003, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h8000_0000_0001, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hC000_0000_0003, 1'b1}, 1'b0, NoGolden},
      '{PLAN_MASKS, 9'h1FF, 9'h1FF, '{48'h0, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h0, 1'b1}, 1'b1,
        '{48'hFFFF_FFFF_FFFF, 6'd48, 6'd48, 1'b1}},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hAAAA_AAAA_AAAA, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'h5555_5555_5555, 1'b1}, 1'b0, NoGolden},
      '{PLAN_MASKS, 9'h000, 9'h000, '{48'h0, 1'b0}, 1'b0, NoGolden},
      '{PLAN_ROW, 9'd0, 9'd0, '{48'hFFFF_FFFF_FFFF, 1'b1}, 1'b1,
        '{48'h0, 6'd0, 6'd48, 1'b1}},
      '{PLAN_MASKS, 9'd8, 9'd12, '{48'h0, 1'b0}, 1'b0, NoGolden}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // model of the block
   logic [RowBits-1:0]  above_row;
   logic [RowBits-1:0]  middle_row;
   logic                middle_loaded;
   logic [MaskBits-1:0] birth_rule;
   logic [MaskBits-1:0] survive_rule;
   rsp_type             pending_rows [$];

   logic    golden_pending;
   rsp_type golden_value;
   logic    hold_rsp_request;
   int      burst_left;
   int      mismatch_count;
   int      cycle_count;

   life_like_automaton_row_step_unit #(
      .GRID_COLUMNS(GridColumns)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [RowBits-1:0] next_generation(input logic [RowBits-1:0] up,
                                                          input logic [RowBits-1:0] mid,
                                                          input logic [RowBits-1:0] down);
      logic [RowBits-1:0]  result;
      logic [MaskBits-1:0] rule;
      int                  neighbors;
      int                  col;
      result = '0;
      for (int c = 0; c < GridWidth; c++) begin
         neighbors = 0;
         for (int d = -1; d <= 1; d++) begin
            col = c + d;
            if (col >= 0 && col < GridWidth) begin
               neighbors += up[col] + down[col];
               if (d != 0)
                  neighbors += mid[col];
            end
         end
         rule = mid[c] ? survive_rule : birth_rule;
         result[c] = rule[neighbors];
      end
      return result;
   endfunction

   function automatic void push_evolved(input logic [RowBits-1:0] prior,
                                        input logic [RowBits-1:0] evolved,
                                        input logic last);
      rsp_type r;
      r.next_row_bits     = evolved & GridMask;
      r.row_alive_count   = CountBits'($countones(evolved & GridMask));
      r.row_changed_count = CountBits'($countones((prior ^ evolved) & GridMask));
      r.last_of_frame     = last;
      pending_rows.push_back(r);
   endfunction

   function automatic void clear_rows();
      above_row     = '0;
      middle_row    = '0;
      middle_loaded = 1'b0;
   endfunction

   function automatic void step_generation(input req_type item);
      logic [RowBits-1:0] cur;
      cur = item.row_bits & GridMask;
      if (middle_loaded) begin
         push_evolved(middle_row, next_generation(above_row, middle_row, cur), 1'b0);
         if (item.last_row) begin
            push_evolved(cur, next_generation(middle_row, cur, '0), 1'b1);
            clear_rows();
         end else begin
            above_row  = middle_row;
            middle_row = cur;
         end
      end else if (item.last_row) begin
         push_evolved(cur, next_generation('0, cur, '0), 1'b1);
         clear_rows();
      end else begin
         above_row     = '0;
         middle_row    = cur;
         middle_loaded = 1'b1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            step_generation(req_payload);
            if (golden_pending)
               pending_rows[$] = golden_value;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rows.size() == 0) begin
               $error("unexpected item: next_row_bits %0h", rsp_payload.next_row_bits);
               mismatch_count++;
            end else begin
               want = pending_rows.pop_front();
               check_field("next_row_bits", 64'(want.next_row_bits),
                           64'(rsp_payload.next_row_bits));
               check_field("row_alive_count", 64'(want.row_alive_count),
                           64'(rsp_payload.row_alive_count));
               check_field("row_changed_count", 64'(want.row_changed_count),
                           64'(rsp_payload.row_changed_count));
               check_field("last_of_frame", 64'(want.last_of_frame),
                           64'(rsp_payload.last_of_frame));
            end
         end
      end
   end

   // receiver: stall pattern changes every so often; one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      int tick;
      rsp_ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_left        = HoldCycles;
            hold_rsp_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ready <= (tick % 4 == 0);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** life_like_automaton_row_step_unit: FAILED **");
      $finish;
   end

   task automatic offer_row(input req_type item, input logic has_golden,
                            input rsp_type golden_row);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_payload    <= item;
      golden_pending  = has_golden;
      golden_value    = golden_row;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         pause_sender(gap);
      end
      burst_left--;
   endtask

   // the first row of a frame of two or more rows gives no item, so allow the pipe to settle as well
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rows.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic program_mask(input csr_index_type index, input logic [MaskBits-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == CSR_BIRTH_MASK)
         birth_rule = value;
      else
         survive_rule = value;
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field(index == CSR_BIRTH_MASK ? "birth_mask" : "survive_mask",
                  64'(value), 64'(csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [RowBits-1:0] random_row();
      logic [RowBits-1:0] a;
      logic [RowBits-1:0] b;
      logic [RowBits-1:0] c;
      a = RowBits'({$urandom, $urandom});
      b = RowBits'({$urandom, $urandom});
      c = RowBits'({$urandom, $urandom});
      case ($urandom_range(0, 7))
         0, 1, 2: return a;
         3, 4:    return a & b;
         5:       return a & b & c;
         6:       return a | b;
         default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      endcase
   endfunction

   initial begin
      req_type              item;
      logic [MaskBits-1:0]  birth_pick;
      logic [MaskBits-1:0]  survive_pick;
      int                   rows_offered;
      int                   phase;
      int                   frames;
      int                   height;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      golden_pending   = 1'b0;
      golden_value     = '0;
      hold_rsp_request = 1'b0;
      burst_left       = 0;
      mismatch_count   = 0;
      cycle_count      = 0;
      birth_rule       = BirthMaskReset;
      survive_rule     = SurviveMaskReset;
      clear_rows();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumDirected; i++) begin
         if (DirectedPlan[i].kind == PLAN_MASKS) begin
            wait_until_drained();
            program_mask(CSR_BIRTH_MASK, DirectedPlan[i].birth);
            program_mask(CSR_SURVIVE_MASK, DirectedPlan[i].survive);
         end else begin
            offer_row(DirectedPlan[i].row_in, DirectedPlan[i].check_golden,
                      DirectedPlan[i].golden);
         end
      end

      rows_offered = 0;
      phase        = 0;
      while (rows_offered < RandomRows) begin
         wait_until_drained();
         case ($urandom_range(0, 7))
            0: begin birth_pick = 9'd8;   survive_pick = 9'd12;  end
            1: begin birth_pick = 9'h000; survive_pick = 9'h1FF; end
            2: begin birth_pick = 9'h1FF; survive_pick = 9'h000; end
            3: begin birth_pick = 9'd72;  survive_pick = 9'd12;  end
            default: begin
               birth_pick   = MaskBits'($urandom);
               survive_pick = MaskBits'($urandom);
            end
         endcase
         program_mask(CSR_BIRTH_MASK, birth_pick);
         program_mask(CSR_SURVIVE_MASK, survive_pick);
         frames = $urandom_range(3, 12);
         for (int f = 0; f < frames; f++) begin
            // block fills and back-pressures while the receiver holds off
            if (phase == 2 && f == 1)
               hold_rsp_request = 1'b1;
            case ($urandom_range(0, 15))
               0, 1:    height = 1;
               2:       height = $urandom_range(20, 40);
               default: height = $urandom_range(2, 10);
            endcase
            for (int r = 0; r < height; r++) begin
               pace_sender();
               item.row_bits = random_row();
               item.last_row = (r == height - 1);
               offer_row(item, 1'b0, NoGolden);
               rows_offered++;
            end
         end
         phase++;
      end

      wait_until_drained();
      if (mismatch_count == 0)
         $display("** life_like_automaton_row_step_unit: PASSED **");
      else
         $display("** life_like_automaton_row_step_unit: FAILED **");
      $finish;
   end

endmodule

>>> files.f
design/llars_pkg.sv
design/llars_cell.sv
design/life_like_automaton_row_step_unit.sv
test/life_like_automaton_row_step_unit_test.sv
